// ===== src/kt_pkg.sv =====
`timescale 1ns / 1ps

package kt_pkg;

    localparam int OFFSET_WIDTH = 16;
    localparam int PREFIX_DEPTH = 9;
    localparam int PFX_IDX_W    = $clog2(PREFIX_DEPTH);
    localparam int KW_COUNT     = 9;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FILL_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_EQUAL = 8'd61;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UP_A  = 8'd65;
    localparam logic [7:0] CH_UP_Z  = 8'd90;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_Z  = 8'd122;

    typedef enum logic [4:0] {
        KIND_INPUT     = 5'd0,
        KIND_DISPLAY   = 5'd1,
        KIND_IDENT     = 5'd2,
        KIND_INT       = 5'd3,
        KIND_EQUAL     = 5'd4,
        KIND_INVALID   = 5'd5,
        KIND_END       = 5'd6,
        KIND_PLUS      = 5'd7,
        KIND_MINUS     = 5'd8,
        KIND_STAR      = 5'd9,
        KIND_SLASH     = 5'd10,
        KIND_SET       = 5'd11,
        KIND_TO        = 5'd12,
        KIND_IF        = 5'd13,
        KIND_GREATER   = 5'd14,
        KIND_THEN      = 5'd15,
        KIND_OTHERWISE = 5'd16,
        KIND_REPEAT    = 5'd17,
        KIND_TIMES     = 5'd18
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_WORD = 2'd2
    } scan_mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  bad;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // keyword text is right aligned: last character in byte 0
    typedef struct packed {
        logic [PREFIX_DEPTH*8-1:0] text;
        logic [PFX_IDX_W-1:0]      len;
        kind_t                     kind;
    } kw_t;

    localparam kw_t KW_TABLE [KW_COUNT] = '{
        '{(PREFIX_DEPTH*8)'("input"),     PFX_IDX_W'(5), KIND_INPUT},
        '{(PREFIX_DEPTH*8)'("display"),   PFX_IDX_W'(7), KIND_DISPLAY},
        '{(PREFIX_DEPTH*8)'("set"),       PFX_IDX_W'(3), KIND_SET},
        '{(PREFIX_DEPTH*8)'("to"),        PFX_IDX_W'(2), KIND_TO},
        '{(PREFIX_DEPTH*8)'("if"),        PFX_IDX_W'(2), KIND_IF},
        '{(PREFIX_DEPTH*8)'("then"),      PFX_IDX_W'(4), KIND_THEN},
        '{(PREFIX_DEPTH*8)'("otherwise"), PFX_IDX_W'(9), KIND_OTHERWISE},
        '{(PREFIX_DEPTH*8)'("repeat"),    PFX_IDX_W'(6), KIND_REPEAT},
        '{(PREFIX_DEPTH*8)'("times"),     PFX_IDX_W'(5), KIND_TIMES}
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic kw_match(input prefix_t pfx, input logic [15:0] cnt,
                                      input kw_t kw);
        logic hit;
        int   pos;
        hit = (cnt == 16'(kw.len));
        for (int i = 0; i < PREFIX_DEPTH; i++)
        begin
            pos = int'(kw.len) - 1 - i;
            if (pos >= 0)
            begin
                if (pfx[i] != kw.text[pos*8 +: 8])
                    hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic kind_t word_kind(input prefix_t pfx, input logic [15:0] cnt);
        kind_t k;
        k = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (kw_match(pfx, cnt, KW_TABLE[i]))
                k = KW_TABLE[i].kind;
        end
        return k;
    endfunction

endpackage

// ===== src/kt_if.sv =====
`timescale 1ns / 1ps

interface kt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  bad_byte;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output bad_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input bad_byte, input last_of_run,
                    output ready);
endinterface

// ===== src/kt_scan.sv =====
`timescale 1ns / 1ps

module kt_scan
(
    input  logic                clk,
    input  logic                rst_n,
    kt_in_if.sink               text,
    input  logic                space_ok,
    output kt_pkg::push_t       push
);

    kt_pkg::scan_mode_t                 mode_reg, mode_next;
    logic [kt_pkg::OFFSET_WIDTH-1:0]    pos_reg, pos_next;
    logic [kt_pkg::OFFSET_WIDTH-1:0]    start_reg, start_next;
    logic [15:0]                        count_reg, count_next;
    kt_pkg::prefix_t                    prefix_reg, prefix_next;

    logic        accept;
    logic [7:0]  b;
    logic        eot;
    logic        digit, alpha, space;
    logic        cont_int, cont_word;
    logic [15:0] count_inc;
    logic [kt_pkg::OFFSET_WIDTH-1:0] pos_inc;
    logic        have_flush, have_own;
    kt_pkg::tok_t flush_tok, own_tok;

    assign text.ready = space_ok;
    assign accept     = text.valid && text.ready;
    assign b          = text.text_byte;
    assign eot        = text.end_of_text;
    assign digit      = kt_pkg::is_digit(b);
    assign alpha      = kt_pkg::is_alpha(b);
    assign space      = kt_pkg::is_space(b);
    assign cont_int   = (mode_reg == kt_pkg::MODE_INT) && digit;
    assign cont_word  = (mode_reg == kt_pkg::MODE_WORD) && (alpha || (b == kt_pkg::CH_MINUS));
    assign count_inc  = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    assign pos_inc    = pos_reg + kt_pkg::OFFSET_WIDTH'(1);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        prefix_next = prefix_reg;
        if (accept)
        begin
            if (eot)
            begin
                mode_next = kt_pkg::MODE_IDLE;
                pos_next  = '0;
            end
            else if (cont_int)
            begin
                count_next = count_inc;
                pos_next   = pos_inc;
            end
            else if (cont_word)
            begin
                if (count_reg < 16'(kt_pkg::PREFIX_DEPTH))
                    prefix_next[count_reg[kt_pkg::PFX_IDX_W-1:0]] = b;
                count_next = count_inc;
                pos_next   = pos_inc;
            end
            else
            begin
                mode_next = kt_pkg::MODE_IDLE;
                pos_next  = pos_inc;
                if (digit)
                begin
                    mode_next  = kt_pkg::MODE_INT;
                    start_next = pos_reg;
                    count_next = 16'd1;
                end
                else if (alpha)
                begin
                    mode_next      = kt_pkg::MODE_WORD;
                    start_next     = pos_reg;
                    count_next     = 16'd1;
                    prefix_next[0] = b;
                end
            end
        end
    end

    // token outputs
    always_comb
    begin
        have_flush = accept && (mode_reg != kt_pkg::MODE_IDLE)
                     && (eot || !(cont_int || cont_word));

        own_tok.kind   = kt_pkg::KIND_END;
        own_tok.start  = 16'(pos_reg);
        own_tok.length = 16'd1;
        own_tok.bad    = 8'd0;
        own_tok.last   = 1'b1;
        have_own       = 1'b0;
        if (accept)
        begin
            priority if (eot)
            begin
                have_own       = 1'b1;
                own_tok.length = 16'd0;
            end
            else if (cont_int || cont_word || space || digit || alpha)
                have_own = 1'b0;
            else if (b == kt_pkg::CH_EQUAL)
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_EQUAL;
            end
            else if (b == kt_pkg::CH_PLUS)
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_PLUS;
            end
            else if (b == kt_pkg::CH_MINUS)
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_MINUS;
            end
            else if (b == kt_pkg::CH_STAR)
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_STAR;
            end
            else if (b == kt_pkg::CH_SLASH)
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_SLASH;
            end
            else
            begin
                have_own     = 1'b1;
                own_tok.kind = kt_pkg::KIND_INVALID;
                own_tok.bad  = b;
            end
        end

        flush_tok.kind   = (mode_reg == kt_pkg::MODE_INT) ? kt_pkg::KIND_INT
                           : kt_pkg::word_kind(prefix_reg, count_reg);
        flush_tok.start  = 16'(start_reg);
        flush_tok.length = count_reg;
        flush_tok.bad    = 8'd0;
        flush_tok.last   = !have_own;

        push.cnt  = 2'({1'b0, have_flush} + {1'b0, have_own});
        push.tok0 = have_flush ? flush_tok : own_tok;
        push.tok1 = own_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= kt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
    end

    a_eot_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eot |=> pos_reg == '0 && mode_reg == kt_pkg::MODE_IDLE)
        else $error("position or mode not cleared after end of text");

    a_eot_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eot |-> (push.cnt == 2'd1 && push.tok0.last)
                          || (push.cnt == 2'd2 && push.tok1.last))
        else $error("end of text without final token");

    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != kt_pkg::MODE_IDLE |-> count_reg != 16'd0)
        else $error("pending token with zero length");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> !push.tok0.last && push.tok0.kind != kt_pkg::KIND_END)
        else $error("flushed token marked last ahead of a second token");

endmodule

// ===== src/kt_out_fifo.sv =====
`timescale 1ns / 1ps

module kt_out_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  kt_pkg::push_t  push,
    output logic           space_ok,
    kt_out_if.source       tokens
);

    kt_pkg::tok_t                 mem_reg [kt_pkg::FIFO_DEPTH];
    logic [kt_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [kt_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [kt_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                         pop;
    kt_pkg::tok_t                 head;

    assign space_ok = fill_reg <= kt_pkg::FILL_W'(kt_pkg::FIFO_DEPTH - 2);
    assign pop      = tokens.valid && tokens.ready;
    assign head     = mem_reg[rd_ptr_reg];

    assign tokens.valid        = fill_reg != '0;
    assign tokens.token_kind   = head.kind;
    assign tokens.start_offset = head.start;
    assign tokens.token_length = head.length;
    assign tokens.bad_byte     = head.bad;
    assign tokens.last_of_run  = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + kt_pkg::PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + kt_pkg::PTR_W'(pop);
        fill_next   = fill_reg + kt_pkg::FILL_W'(push.cnt) - kt_pkg::FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push.tok0;
        if (push.cnt == 2'd2)
            mem_reg[wr_ptr_reg + kt_pkg::PTR_W'(1)] <= push.tok1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= kt_pkg::FILL_W'(kt_pkg::FIFO_DEPTH))
        else $error("token queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> space_ok)
        else $error("tokens pushed without room");

    a_pair_fill: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 && !pop |=> fill_reg == $past(fill_reg) + kt_pkg::FILL_W'(2))
        else $error("token pair not counted");

endmodule

// ===== src/keyword_tokenizer_core.sv =====
`timescale 1ns / 1ps

// channel   direction  payload
// text      in         text_byte[7:0], end_of_text
// tokens    out        token_kind[4:0], start_offset[15:0], token_length[15:0],
//                      bad_byte[7:0], last_of_run
//
// one text transaction per cycle while text.ready is high; each pushes 0, 1 or 2 tokens into the registered queue
// tokens drain one per cycle while tokens.ready is high, through a four-entry queue
// text.ready drops while fewer than two queue entries are free
// rst_n clears scan mode, position and queue; no clearing pass
module keyword_tokenizer_core
(
    input  logic      clk,
    input  logic      rst_n,
    kt_in_if.sink     text,
    kt_out_if.source  tokens
);

    kt_pkg::push_t push;
    logic          space_ok;

    kt_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .space_ok (space_ok),
        .push     (push)
    );

    kt_out_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .tokens   (tokens)
    );

endmodule

// ===== test/keyword_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps

module keyword_tokenizer_core_tb;

    localparam int N_DIRECTED     = 25;
    localparam int RANDOM_ITEMS   = 1920;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [7:0]   text_byte;
        logic         eot;
        int           fixed_count;
        kt_pkg::tok_t fixed_tok;
    } text_row_t;

    logic clk;
    logic rst_n;
    logic sink_ready = 1'b0;
    logic [7:0] ready_bits = 8'hFF;
    logic [2:0] ready_phase = 3'd0;

    kt_in_if  text_if ();
    kt_out_if tok_if ();

    assign tok_if.ready = sink_ready;

    keyword_tokenizer_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .tokens (tok_if)
    );

    string         keyword_text [kt_pkg::KW_COUNT] = '{"input", "display", "set", "to", "if",
                                                       "then", "otherwise", "repeat", "times"};
    kt_pkg::kind_t keyword_kind [kt_pkg::KW_COUNT] = '{kt_pkg::KIND_INPUT, kt_pkg::KIND_DISPLAY,
                                                       kt_pkg::KIND_SET, kt_pkg::KIND_TO,
                                                       kt_pkg::KIND_IF, kt_pkg::KIND_THEN,
                                                       kt_pkg::KIND_OTHERWISE,
                                                       kt_pkg::KIND_REPEAT, kt_pkg::KIND_TIMES};
    logic [7:0]    op_chars [5] = '{kt_pkg::CH_EQUAL, kt_pkg::CH_PLUS, kt_pkg::CH_MINUS,
                                    kt_pkg::CH_STAR, kt_pkg::CH_SLASH};

    // tokenizer state as seen from the text stream
    kt_pkg::scan_mode_t scan_state = kt_pkg::MODE_IDLE;
    logic [15:0]  next_offset = 16'd0;
    logic [15:0]  pending_start = 16'd0;
    logic [15:0]  pending_len = 16'd0;
    logic [7:0]   word_bytes [kt_pkg::PREFIX_DEPTH];
    kt_pkg::tok_t step_tokens [2];
    int           step_count;

    kt_pkg::tok_t expected_tokens [$];
    kt_pkg::tok_t seen_token;
    kt_pkg::tok_t want_token;
    text_row_t    directed_rows [N_DIRECTED];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           random_items = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic kt_pkg::tok_t make_token(input kt_pkg::kind_t k, input logic [15:0] s,
                                                input logic [15:0] l, input logic [7:0] bad,
                                                input logic last);
        kt_pkg::tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.bad    = bad;
        t.last   = last;
        return t;
    endfunction

    function automatic kt_pkg::kind_t keyword_lookup();
        logic hit;
        for (int i = 0; i < kt_pkg::KW_COUNT; i++)
        begin
            hit = (pending_len == 16'(keyword_text[i].len()));
            for (int j = 0; j < keyword_text[i].len(); j++)
            begin
                if (hit && word_bytes[j] != keyword_text[i][j])
                    hit = 1'b0;
            end
            if (hit)
                return keyword_kind[i];
        end
        return kt_pkg::KIND_IDENT;
    endfunction

    function automatic logic [7:0] letter_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(kt_pkg::CH_UP_A, kt_pkg::CH_UP_Z));
        return 8'($urandom_range(kt_pkg::CH_LO_A, kt_pkg::CH_LO_Z));
    endfunction

    task automatic add_token(input kt_pkg::kind_t k, input logic [15:0] s,
                             input logic [15:0] l, input logic [7:0] bad);
        step_tokens[step_count] = make_token(k, s, l, bad, 1'b0);
        step_count++;
    endtask

    task automatic flush_pending();
        if (scan_state == kt_pkg::MODE_INT)
            add_token(kt_pkg::KIND_INT, pending_start, pending_len, 8'h00);
        else if (scan_state == kt_pkg::MODE_WORD)
            add_token(keyword_lookup(), pending_start, pending_len, 8'h00);
        scan_state = kt_pkg::MODE_IDLE;
    endtask

    task automatic tokenize_step(input logic [7:0] b, input logic eot);
        logic is_num;
        logic is_letter;
        logic is_blank;
        is_num    = (b >= kt_pkg::CH_ZERO) && (b <= kt_pkg::CH_NINE);
        is_letter = ((b >= kt_pkg::CH_UP_A) && (b <= kt_pkg::CH_UP_Z))
                    || ((b >= kt_pkg::CH_LO_A) && (b <= kt_pkg::CH_LO_Z));
        is_blank  = (b == kt_pkg::CH_SPACE) || ((b >= kt_pkg::CH_TAB) && (b <= kt_pkg::CH_CR));
        step_count = 0;
        if (eot)
        begin
            flush_pending();
            add_token(kt_pkg::KIND_END, next_offset, 16'd0, 8'h00);
            next_offset = 16'd0;
        end
        else if (scan_state == kt_pkg::MODE_INT && is_num)
        begin
            if (pending_len != 16'hFFFF)
                pending_len++;
            next_offset++;
        end
        else if (scan_state == kt_pkg::MODE_WORD && (is_letter || b == kt_pkg::CH_MINUS))
        begin
            if (pending_len < kt_pkg::PREFIX_DEPTH)
                word_bytes[pending_len] = b;
            if (pending_len != 16'hFFFF)
                pending_len++;
            next_offset++;
        end
        else
        begin
            flush_pending();
            unique case (b)
                kt_pkg::CH_EQUAL: add_token(kt_pkg::KIND_EQUAL, next_offset, 16'd1, 8'h00);
                kt_pkg::CH_PLUS:  add_token(kt_pkg::KIND_PLUS, next_offset, 16'd1, 8'h00);
                kt_pkg::CH_MINUS: add_token(kt_pkg::KIND_MINUS, next_offset, 16'd1, 8'h00);
                kt_pkg::CH_STAR:  add_token(kt_pkg::KIND_STAR, next_offset, 16'd1, 8'h00);
                kt_pkg::CH_SLASH: add_token(kt_pkg::KIND_SLASH, next_offset, 16'd1, 8'h00);
                default:
                begin
                    if (is_num || is_letter)
                    begin
                        scan_state    = is_num ? kt_pkg::MODE_INT : kt_pkg::MODE_WORD;
                        pending_start = next_offset;
                        pending_len   = 16'd1;
                        word_bytes[0] = b;
                    end
                    else if (!is_blank)
                        add_token(kt_pkg::KIND_INVALID, next_offset, 16'd1, b);
                end
            endcase
            next_offset++;
        end
        if (step_count > 0)
            step_tokens[step_count - 1].last = 1'b1;
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(50, 200);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drive_text(input logic [7:0] b, input logic eot, input int fixed_count,
                              input kt_pkg::tok_t fixed_tok);
        pace_sender();
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (text_if.ready !== 1'b1);
        tokenize_step(b, eot);
        if (fixed_count < 0)
        begin
            for (int i = 0; i < step_count; i++)
                expected_tokens.push_back(step_tokens[i]);
        end
        else if (fixed_count > 0)
            expected_tokens.push_back(fixed_tok);
    endtask

    task automatic send_random_phrase();
        int choice;
        int len;
        int kw;
        int idx;
        logic word_like;
        logic [7:0] phrase [$];
        choice    = $urandom_range(0, 99);
        word_like = 1'b1;
        if (choice < 35)
        begin
            kw = $urandom_range(0, kt_pkg::KW_COUNT - 1);
            for (int j = 0; j < keyword_text[kw].len(); j++)
                phrase.push_back(keyword_text[kw][j]);
            case ($urandom_range(0, 7))
                0: void'(phrase.pop_back());
                1: phrase.push_back(letter_char());
                2:
                begin
                    idx = $urandom_range(0, phrase.size() - 1);
                    phrase[idx] = phrase[idx] ^ 8'h20;
                end
                default: ;
            endcase
        end
        else if (choice < 50)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
            phrase.push_back(letter_char());
            for (int j = 1; j < len; j++)
                phrase.push_back(($urandom_range(0, 4) == 0) ? kt_pkg::CH_MINUS
                                                              : letter_char());
        end
        else if (choice < 62)
        begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++)
                phrase.push_back(8'($urandom_range(kt_pkg::CH_ZERO, kt_pkg::CH_NINE)));
        end
        else
        begin
            word_like = 1'b0;
            if (choice < 74)
                phrase.push_back(op_chars[$urandom_range(0, 4)]);
            else if (choice < 90)
                phrase.push_back(8'($urandom_range(0, 255)));
            else if (choice < 94)
            begin
                drive_text(8'($urandom), 1'b1, -1, '0);
                random_items++;
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int j = 0; j < len; j++)
                    drive_text(8'($urandom_range(kt_pkg::CH_TAB, kt_pkg::CH_CR)), 1'b0, -1, '0);
            end
        end
        if (word_like && $urandom_range(0, 7) != 0)
        begin
            if ($urandom_range(0, 1) == 0)
                phrase.push_back(($urandom_range(0, 1) == 0)
                                 ? kt_pkg::CH_SPACE
                                 : 8'($urandom_range(kt_pkg::CH_TAB, kt_pkg::CH_CR)));
            else
                phrase.push_back(op_chars[$urandom_range(0, 4)]);
        end
        foreach (phrase[j])
            drive_text(phrase[j], 1'b0, -1, '0);
        random_items += phrase.size();
    endtask

    task automatic note_mismatch(input string what, input kt_pkg::tok_t want,
                                 input kt_pkg::tok_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s at %0t: expected kind %0d start %0d length %0d bad %02h last %0b",
                     what, $time, want.kind, want.start, want.length, want.bad, want.last);
            $display("    got kind %0d start %0d length %0d bad %02h last %0b",
                     got.kind, got.start, got.length, got.bad, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_if.valid && text_if.ready) || (tok_if.valid && sink_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (tok_if.valid && sink_ready)
            begin
                seen_token.kind   = kt_pkg::kind_t'(tok_if.token_kind);
                seen_token.start  = tok_if.start_offset;
                seen_token.length = tok_if.token_length;
                seen_token.bad    = tok_if.bad_byte;
                seen_token.last   = tok_if.last_of_run;
                if (expected_tokens.size() == 0)
                    note_mismatch("unexpected token transaction", '0, seen_token);
                else
                begin
                    want_token = expected_tokens.pop_front();
                    if (want_token.kind !== seen_token.kind
                        || want_token.start !== seen_token.start
                        || want_token.length !== seen_token.length
                        || want_token.bad !== seen_token.bad
                        || want_token.last !== seen_token.last)
                        note_mismatch("token mismatch", want_token, seen_token);
                end
            end
        end
        // stall pattern, reloaded when ready_phase reaches 7; bit 0 always set
        if (ready_phase == 3'd7)
        begin
            case ($urandom_range(0, 3))
                0:       ready_bits <= 8'hFF;
                1:       ready_bits <= 8'h11;
                default: ready_bits <= 8'($urandom) | 8'h01;
            endcase
        end
        ready_phase <= ready_phase + 3'd1;
        sink_ready  <= ready_bits[ready_phase];
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        text_if.valid       <= 1'b0;
        text_if.text_byte   <= 8'h00;
        text_if.end_of_text <= 1'b0;
        directed_rows = '{
            '{8'h00, 1'b1, 1,
              make_token(kt_pkg::KIND_END,     16'd0,  16'd0, 8'h00, 1'b1)},
            '{8'hFF, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd0,  16'd1, 8'hFF, 1'b1)},
            '{8'h80, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd1,  16'd1, 8'h80, 1'b1)},
            '{8'h00, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd2,  16'd1, 8'h00, 1'b1)},
            '{8'h7F, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd3,  16'd1, 8'h7F, 1'b1)},
            '{kt_pkg::CH_EQUAL, 1'b0, 1,
              make_token(kt_pkg::KIND_EQUAL,   16'd4,  16'd1, 8'h00, 1'b1)},
            '{kt_pkg::CH_PLUS,  1'b0, 1,
              make_token(kt_pkg::KIND_PLUS,    16'd5,  16'd1, 8'h00, 1'b1)},
            '{kt_pkg::CH_MINUS, 1'b0, 1,
              make_token(kt_pkg::KIND_MINUS,   16'd6,  16'd1, 8'h00, 1'b1)},
            '{kt_pkg::CH_STAR,  1'b0, 1,
              make_token(kt_pkg::KIND_STAR,    16'd7,  16'd1, 8'h00, 1'b1)},
            '{kt_pkg::CH_SLASH, 1'b0, 1,
              make_token(kt_pkg::KIND_SLASH,   16'd8,  16'd1, 8'h00, 1'b1)},
            '{kt_pkg::CH_SPACE, 1'b0, 0, '0},
            '{kt_pkg::CH_TAB,   1'b0, 0, '0},
            '{kt_pkg::CH_CR,    1'b0, 0, '0},
            '{8'h08, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd12, 16'd1, 8'h08, 1'b1)},
            '{8'h0E, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd13, 16'd1, 8'h0E, 1'b1)},
            '{kt_pkg::CH_ZERO,  1'b0, -1, '0},
            '{kt_pkg::CH_NINE,  1'b0, -1, '0},
            '{"i",              1'b0, -1, '0},
            '{"f",              1'b0, -1, '0},
            '{kt_pkg::CH_PLUS,  1'b0, -1, '0},
            '{"a",              1'b0, -1, '0},
            '{kt_pkg::CH_MINUS, 1'b0, -1, '0},
            '{kt_pkg::CH_UP_Z,  1'b0, -1, '0},
            '{8'h5A,            1'b1, -1, '0},
            '{8'h40, 1'b0, 1,
              make_token(kt_pkg::KIND_INVALID, 16'd0,  16'd1, 8'h40, 1'b1)}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            drive_text(directed_rows[i].text_byte, directed_rows[i].eot,
                       directed_rows[i].fixed_count, directed_rows[i].fixed_tok);

        while (random_items < RANDOM_ITEMS)
            send_random_phrase();
        drive_text(8'($urandom), 1'b1, -1, '0);

        text_if.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
